>>> rtl/brb_pkg.sv
// Shared types and constants for the byte ring buffer with mark and rewind.
`timescale 1ns / 1ps
`default_nettype none
package brb_pkg;

    localparam int BRB_DEPTH     = 256;
    localparam int BRB_MAX_BURST = 8;

    // Field widths fixed by the stream format
    localparam int OP_W      = 3;
    localparam int DATA_W    = 64;
    localparam int COUNT_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int LEVEL_W   = 8;
    localparam int BIDX_W    = 3;   // byte lane within the 64-bit burst word
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 88;

    typedef enum logic [OP_W-1:0] {
        OP_PUT     = 3'd0,
        OP_GET     = 3'd1,
        OP_DISCARD = 3'd2,
        OP_PEEK    = 3'd3,
        OP_MARK    = 3'd4,
        OP_REWIND  = 3'd5,
        OP_RESET   = 3'd6
    } brb_op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_SHORT = 2'd1,
        STAT_RANGE = 2'd2
    } brb_status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_PUT,
        S_GET,
        S_GET_TAIL,
        S_DISC,
        S_PEEK,
        S_FINISH
    } brb_state_t;

endpackage
`default_nettype wire

>>> rtl/brb_alu.sv
// Shared modular pointer adder/subtractor (result modulo DEPTH).
`timescale 1ns / 1ps
`default_nettype none
module brb_alu #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          sub,
    input  wire logic [AW-1:0] a,
    input  wire logic [AW-1:0] b,
    output logic      [AW-1:0] y
);

    localparam logic [AW:0] DEPTH_X = (AW+1)'(DEPTH);

    logic [AW:0] sum;
    logic [AW:0] fixed;

    always_comb begin
        if (sub) begin
            sum   = {1'b0, a} - {1'b0, b};
            fixed = sum + DEPTH_X;
            y     = sum[AW] ? fixed[AW-1:0] : sum[AW-1:0];
        end else begin
            sum   = {1'b0, a} + {1'b0, b};
            fixed = sum - DEPTH_X;
            y     = (sum >= DEPTH_X) ? fixed[AW-1:0] : sum[AW-1:0];
        end
    end

endmodule
`default_nettype wire

>>> rtl/brb_mem.sv
// Byte store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module brb_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/byte_ring_buffer_mark_rewind.sv
// Top level: byte ring buffer with mark/rewind, sequencer and pointer logic.
`timescale 1ns / 1ps
`default_nettype none
// Circular byte FIFO of DEPTH bytes (at most DEPTH-1 held) taking one operation per
// transaction: put/get of 1 to 8 bytes, discard, peek, mark, rewind and pointer reset.
// Every item yields one result carrying data, status, backlog and free space.
// Bytes move one per cycle through the byte store, with its separate write and read
// ports, and a single modular pointer adder serves occupancy, increments and discards.
// Each item is accepted in idle, evaluated, moved byte by byte for put and get, and
// finished in a state that waits while the result register is held; then idle again.
// After reset the store is zeroed in a clearing pass over all DEPTH addresses, with s_tready low.
module byte_ring_buffer_mark_rewind
    import brb_pkg::*;
#(
    parameter int DEPTH = BRB_DEPTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // write_bytes [63:0], byte_count [79:64]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // operation [2:0]
    input  wire logic [OP_W-1:0]      s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // read_bytes [63:0], status [65:64], backlog [73:66], free_space [81:74], zero [87:82]
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] ONE_PTR  = PTR_W'(1);

    brb_state_t             state_reg, state_next;
    brb_op_t                op_reg, op_next;
    logic [DATA_W-1:0]      wdata_reg, wdata_next;
    logic [COUNT_W-1:0]     cnt_reg, cnt_next;
    logic [PTR_W-1:0]       wp_reg, wp_next;
    logic [PTR_W-1:0]       rp_reg, rp_next;
    logic [PTR_W-1:0]       mark_reg, mark_next;
    logic [PTR_W-1:0]       clr_reg, clr_next;
    logic [BIDX_W-1:0]      idx_reg, idx_next;
    logic [BIDX_W-1:0]      pidx_reg, pidx_next;
    logic                   pend_reg, pend_next;
    logic [DATA_W-1:0]      rd_reg, rd_next;
    brb_status_t            status_reg, status_next;
    logic                   m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;

    // shared pointer unit
    logic             alu_sub;
    logic [PTR_W-1:0] alu_a, alu_b, alu_y;

    // byte store ports
    logic             mem_wr_en, mem_rd_en;
    logic [PTR_W-1:0] mem_wr_addr, mem_rd_addr;
    logic [7:0]       mem_wr_data, mem_rd_data;

    logic [PTR_W+COUNT_W-1:0] held_x, room_x, cnt_x;
    logic [PTR_W-1:0]         room;
    logic [PTR_W+7:0]         held_w, room_w;
    logic                     cnt_bad, last_byte, out_free;

    brb_alu #(
        .DEPTH (DEPTH),
        .AW    (PTR_W)
    ) u_alu (
        .sub (alu_sub),
        .a   (alu_a),
        .b   (alu_b),
        .y   (alu_y)
    );

    brb_mem #(
        .DEPTH (DEPTH),
        .AW    (PTR_W)
    ) u_mem (
        .clk     (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // alu_y is the backlog whenever the unit is in subtract mode
    assign room    = LAST_PTR - alu_y;
    assign held_x  = {{COUNT_W{1'b0}}, alu_y};
    assign room_x  = {{COUNT_W{1'b0}}, room};
    assign cnt_x   = {{PTR_W{1'b0}}, cnt_reg};
    assign held_w  = {8'd0, alu_y};
    assign room_w  = {8'd0, room};
    assign cnt_bad = (cnt_reg == '0) || (cnt_reg > COUNT_W'(BRB_MAX_BURST));
    assign last_byte = (({1'b0, idx_reg} + 4'd1) == cnt_reg[BIDX_W:0]);
    assign out_free  = !m_valid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            wp_reg      <= '0;
            rp_reg      <= '0;
            mark_reg    <= '0;
            clr_reg     <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            mark_reg    <= mark_next;
            clr_reg     <= clr_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        wdata_reg  <= wdata_next;
        cnt_reg    <= cnt_next;
        pidx_reg   <= pidx_next;
        rd_reg     <= rd_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        wdata_next   = wdata_reg;
        cnt_next     = cnt_reg;
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        mark_next    = mark_reg;
        clr_next     = clr_reg;
        idx_next     = idx_reg;
        pidx_next    = pidx_reg;
        pend_next    = pend_reg;
        rd_next      = rd_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        alu_sub = 1'b1;
        alu_a   = wp_reg;
        alu_b   = rp_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = wp_reg;
        mem_wr_data = wdata_reg[{idx_reg, 3'b000} +: 8];
        mem_rd_en   = 1'b0;
        mem_rd_addr = rp_reg;

        case (state_reg)
            S_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                mem_wr_data = 8'd0;
                clr_next    = clr_reg + ONE_PTR;
                if (clr_reg == LAST_PTR) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = brb_op_t'(s_tuser);
                    wdata_next  = s_tdata[DATA_W-1:0];
                    cnt_next    = s_tdata[DATA_W +: COUNT_W];
                    rd_next     = '0;
                    status_next = STAT_DONE;
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL: begin
                state_next = S_FINISH;
                case (op_reg)
                    OP_PUT: begin
                        if (cnt_bad) begin
                            status_next = STAT_RANGE;
                        end else if (room_x < cnt_x) begin
                            status_next = STAT_SHORT;
                        end else begin
                            state_next = S_PUT;
                        end
                    end
                    OP_GET: begin
                        if (cnt_bad) begin
                            status_next = STAT_RANGE;
                        end else if (held_x < cnt_x) begin
                            status_next = STAT_SHORT;
                        end else begin
                            state_next = S_GET;
                        end
                    end
                    OP_DISCARD: begin
                        if (held_x < cnt_x) begin
                            status_next = STAT_SHORT;
                        end else begin
                            state_next = S_DISC;
                        end
                    end
                    OP_PEEK: begin
                        if (alu_y == '0) begin
                            status_next = STAT_SHORT;
                        end else begin
                            mem_rd_en  = 1'b1;
                            state_next = S_PEEK;
                        end
                    end
                    OP_MARK: begin
                        mark_next = rp_reg;
                    end
                    OP_REWIND: begin
                        rp_next = mark_reg;
                    end
                    OP_RESET: begin
                        rp_next = '0;
                        wp_next = '0;
                    end
                    default: begin
                        status_next = STAT_RANGE;
                    end
                endcase
            end
            S_PUT: begin
                alu_sub   = 1'b0;
                alu_a     = wp_reg;
                alu_b     = ONE_PTR;
                mem_wr_en = 1'b1;
                wp_next   = alu_y;
                idx_next  = idx_reg + 1'b1;
                if (last_byte) begin
                    state_next = S_FINISH;
                end
            end
            S_GET: begin
                alu_sub   = 1'b0;
                alu_a     = rp_reg;
                alu_b     = ONE_PTR;
                mem_rd_en = 1'b1;
                rp_next   = alu_y;
                if (pend_reg) begin
                    rd_next[{pidx_reg, 3'b000} +: 8] = mem_rd_data;
                end
                pend_next = 1'b1;
                pidx_next = idx_reg;
                idx_next  = idx_reg + 1'b1;
                if (last_byte) begin
                    state_next = S_GET_TAIL;
                end
            end
            S_GET_TAIL: begin
                // last read of the burst lands in the cycle after its address
                rd_next[{pidx_reg, 3'b000} +: 8] = mem_rd_data;
                pend_next  = 1'b0;
                state_next = S_FINISH;
            end
            S_DISC: begin
                alu_sub    = 1'b0;
                alu_a      = rp_reg;
                alu_b      = cnt_reg[PTR_W-1:0];
                rp_next    = alu_y;
                state_next = S_FINISH;
            end
            S_PEEK: begin
                rd_next    = {{(DATA_W-8){1'b0}}, mem_rd_data};
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, room_w[7:0], held_w[7:0], status_reg, rd_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> tb/sv/tb_byte_ring_buffer_mark_rewind.sv
// Self-checking testbench for the byte ring buffer with mark and rewind.
`timescale 1ns / 1ps
module tb_byte_ring_buffer_mark_rewind;
    import brb_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [63:0]        read_bytes;
        brb_status_t        status;
        logic [LEVEL_W-1:0] backlog;
        logic [LEVEL_W-1:0] free_space;
    } ring_result_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        bit                 typed;
        ring_result_t       want;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [OP_W-1:0]      s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    byte_ring_buffer_mark_rewind u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow copy of the ring
    logic [7:0]         ring_store [0:BRB_DEPTH-1];
    logic [LEVEL_W-1:0] ring_wr;
    logic [LEVEL_W-1:0] ring_rd;
    logic [LEVEL_W-1:0] ring_mark;

    ring_result_t pending_results [$];
    ring_result_t seen_res;
    ring_result_t want_res;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int items_sent;
    int results_seen;
    int refusals;
    int full_hits;
    int fail_count;

    dir_row_t dir_rows [0:23] = '{
        '{OP_GET,     64'h0, 16'd1, 1'b1, '{64'h0, STAT_SHORT, 8'd0, 8'd255}},
        '{OP_PEEK,    64'h0, 16'd0, 1'b1, '{64'h0, STAT_SHORT, 8'd0, 8'd255}},
        '{OP_PUT,     64'h0, 16'd0, 1'b1, '{64'h0, STAT_RANGE, 8'd0, 8'd255}},
        '{OP_PUT,     64'hFFFF_FFFF_FFFF_FFFF, 16'd9, 1'b1,
          '{64'h0, STAT_RANGE, 8'd0, 8'd255}},
        '{OP_GET,     64'h0, 16'd0, 1'b1, '{64'h0, STAT_RANGE, 8'd0, 8'd255}},
        '{OP_GET,     64'h0, 16'hFFFF, 1'b1, '{64'h0, STAT_RANGE, 8'd0, 8'd255}},
        '{OP_DISCARD, 64'h0, 16'd0, 1'b1, '{64'h0, STAT_DONE, 8'd0, 8'd255}},
        '{OP_DISCARD, 64'h0, 16'd1, 1'b1, '{64'h0, STAT_SHORT, 8'd0, 8'd255}},
        '{OP_PUT,     64'h8877_6655_4433_2211, 16'd8, 1'b1,
          '{64'h0, STAT_DONE, 8'd8, 8'd247}},
        '{OP_PEEK,    64'h0, 16'd0, 1'b1, '{64'h11, STAT_DONE, 8'd8, 8'd247}},
        '{OP_MARK,    64'h0, 16'd0, 1'b1, '{64'h0, STAT_DONE, 8'd8, 8'd247}},
        '{OP_GET,     64'h0, 16'd8, 1'b1,
          '{64'h8877_6655_4433_2211, STAT_DONE, 8'd0, 8'd255}},
        '{OP_REWIND,  64'h0, 16'd0, 1'b1, '{64'h0, STAT_DONE, 8'd8, 8'd247}},
        '{OP_PUT,     64'hFFFF_FFFF_FFFF_FFFF, 16'd8, 1'b1,
          '{64'h0, STAT_DONE, 8'd16, 8'd239}},
        '{OP_GET,     64'h0, 16'd3, 1'b1, '{64'h33_2211, STAT_DONE, 8'd13, 8'd242}},
        '{OP_DISCARD, 64'h0, 16'd13, 1'b1, '{64'h0, STAT_DONE, 8'd0, 8'd255}},
        '{OP_UNUSED,  64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1,
          '{64'h0, STAT_RANGE, 8'd0, 8'd255}},
        '{OP_RESET,   64'h0, 16'd0, 1'b1, '{64'h0, STAT_DONE, 8'd0, 8'd255}},
        '{OP_PUT,     64'hFFFF_FFFF_FFFF_FFA5, 16'd1, 1'b1,
          '{64'h0, STAT_DONE, 8'd1, 8'd254}},
        '{OP_DISCARD, 64'h0, 16'hFFFF, 1'b1, '{64'h0, STAT_SHORT, 8'd1, 8'd254}},
        '{OP_REWIND,  64'h0, 16'd0, 1'b1, '{64'h0, STAT_DONE, 8'd1, 8'd254}},
        '{OP_GET,     64'h0, 16'd2, 1'b1, '{64'h0, STAT_SHORT, 8'd1, 8'd254}},
        '{OP_PUT,     64'h0000_0001_2345_6789, 16'd5, 1'b0, '0},
        '{OP_GET,     64'h0, 16'd6, 1'b0, '0}
    };

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [LEVEL_W-1:0] ring_held();
        return ring_wr - ring_rd;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Applies one operation to the shadow ring and returns the result it must give
    function automatic ring_result_t ring_apply(input logic [OP_W-1:0] op,
                                                input logic [DATA_W-1:0] data,
                                                input logic [COUNT_W-1:0] count);
        ring_result_t r;
        logic [LEVEL_W-1:0] held;
        int k;
        held = ring_held();
        r = '0;
        r.status = STAT_DONE;
        case (op)
            OP_PUT: begin
                if (count == 0 || count > BRB_MAX_BURST) begin
                    r.status = STAT_RANGE;
                end else if (16'(8'd255 - held) < count) begin
                    r.status = STAT_SHORT;
                end else begin
                    for (k = 0; k < count; k++) begin
                        ring_store[ring_wr] = data[8*k +: 8];
                        ring_wr = ring_wr + 8'd1;
                    end
                end
            end
            OP_GET: begin
                if (count == 0 || count > BRB_MAX_BURST) begin
                    r.status = STAT_RANGE;
                end else if (16'(held) < count) begin
                    r.status = STAT_SHORT;
                end else begin
                    for (k = 0; k < count; k++) begin
                        r.read_bytes[8*k +: 8] = ring_store[ring_rd];
                        ring_rd = ring_rd + 8'd1;
                    end
                end
            end
            OP_DISCARD: begin
                if (16'(held) < count) r.status = STAT_SHORT;
                else ring_rd = ring_rd + count[7:0];
            end
            OP_PEEK: begin
                if (held == 0) r.status = STAT_SHORT;
                else r.read_bytes[7:0] = ring_store[ring_rd];
            end
            OP_MARK:   ring_mark = ring_rd;
            // no check for bytes overwritten since the mark
            OP_REWIND: ring_rd = ring_mark;
            OP_RESET: begin
                ring_rd = '0;
                ring_wr = '0;
            end
            default:   r.status = STAT_RANGE;
        endcase
        held = ring_held();
        r.backlog    = held;
        r.free_space = 8'd255 - held;
        return r;
    endfunction

    task automatic offer_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data,
                            input logic [COUNT_W-1:0] count, input bit typed,
                            input ring_result_t typed_want);
        ring_result_t predicted;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {count, data};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = ring_apply(op, data, count);
        pending_results.push_back(typed ? typed_want : predicted);
        items_sent++;
        if (predicted.status == STAT_SHORT) refusals++;
        if (predicted.backlog == 8'd255) full_hits++;
    endtask

    task automatic pause_until_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic random_op();
        int roll;
        int pick;
        logic [COUNT_W-1:0] cnt;
        logic [LEVEL_W-1:0] held;
        roll = $urandom_range(99);
        held = ring_held();
        cnt  = 16'($urandom_range(BRB_MAX_BURST, 1));
        if ($urandom_range(9) == 0) begin
            if ($urandom_range(1) == 0) cnt = '0;
            else cnt = 16'($urandom_range(65535, BRB_MAX_BURST + 1));
        end
        if (roll < 30) begin
            offer_op(OP_PUT, rand64(), cnt, 1'b0, '0);
        end else if (roll < 55) begin
            offer_op(OP_GET, rand64(), cnt, 1'b0, '0);
        end else if (roll < 65) begin
            pick = $urandom_range(3);
            case (pick)
                0:       cnt = 16'($urandom_range(held));
                1:       cnt = 16'(held);
                2:       cnt = 16'(held) + 16'd1;
                default: cnt = 16'($urandom_range(65535));
            endcase
            offer_op(OP_DISCARD, rand64(), cnt, 1'b0, '0);
        end else if (roll < 75) begin
            offer_op(OP_PEEK, rand64(), 16'($urandom), 1'b0, '0);
        end else if (roll < 84) begin
            offer_op(OP_MARK, rand64(), 16'($urandom), 1'b0, '0);
        end else if (roll < 93) begin
            offer_op(OP_REWIND, rand64(), 16'($urandom), 1'b0, '0);
        end else if (roll < 98) begin
            offer_op(OP_RESET, rand64(), 16'($urandom), 1'b0, '0);
        end else begin
            offer_op(OP_UNUSED, rand64(), 16'($urandom), 1'b0, '0);
        end
    endtask

    task automatic run_phase(input int n);
        int first;
        int roll;
        int guard;
        logic [LEVEL_W-1:0] left;
        first = items_sent;
        while (items_sent - first < n) begin
            roll = $urandom_range(99);
            guard = 0;
            if (roll < 12) begin
                // fill toward full, put the space left, then one more put (refused once full)
                while (8'd255 - ring_held() >= BRB_MAX_BURST && guard < 40) begin
                    offer_op(OP_PUT, rand64(), 16'($urandom_range(BRB_MAX_BURST, 1)),
                             1'b0, '0);
                    guard++;
                end
                left = 8'd255 - ring_held();
                if (left != 0) offer_op(OP_PUT, rand64(), 16'(left), 1'b0, '0);
                offer_op(OP_PUT, rand64(), 16'($urandom_range(BRB_MAX_BURST, 1)),
                         1'b0, '0);
            end else if (roll < 20) begin
                // drain toward empty, get what is left, then one more get (refused once empty)
                while (ring_held() >= BRB_MAX_BURST && guard < 40) begin
                    offer_op(OP_GET, rand64(), 16'($urandom_range(BRB_MAX_BURST, 1)),
                             1'b0, '0);
                    guard++;
                end
                left = ring_held();
                if (left != 0) offer_op(OP_GET, rand64(), 16'(left), 1'b0, '0);
                offer_op(OP_GET, rand64(), 16'($urandom_range(BRB_MAX_BURST, 1)),
                         1'b0, '0);
            end else begin
                random_op();
            end
        end
    endtask

    // Receiver: random back-pressure, or a long hold-off while hold_left runs down
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            seen_res.read_bytes = m_tdata[63:0];
            seen_res.status     = brb_status_t'(m_tdata[65:64]);
            seen_res.backlog    = m_tdata[73:66];
            seen_res.free_space = m_tdata[81:74];
            if (pending_results.size() == 0) begin
                fail_count++;
                $error("result transaction with nothing outstanding");
            end else begin
                want_res = pending_results.pop_front();
                if (seen_res.read_bytes !== want_res.read_bytes) begin
                    fail_count++;
                    $error("read_bytes: expected %h, got %h",
                           want_res.read_bytes, seen_res.read_bytes);
                end
                if (seen_res.status !== want_res.status) begin
                    fail_count++;
                    $error("status: expected %0d, got %0d",
                           want_res.status, seen_res.status);
                end
                if (seen_res.backlog !== want_res.backlog) begin
                    fail_count++;
                    $error("backlog: expected %0d, got %0d",
                           want_res.backlog, seen_res.backlog);
                end
                if (seen_res.free_space !== want_res.free_space) begin
                    fail_count++;
                    $error("free_space: expected %0d, got %0d",
                           want_res.free_space, seen_res.free_space);
                end
            end
        end
    end

    initial begin
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        aresetn       = 1'b0;
        send_idle_pct = 6;
        recv_idle_pct = 82;
        hold_left     = 0;
        items_sent    = 0;
        results_seen  = 0;
        refusals      = 0;
        full_hits     = 0;
        fail_count    = 0;
        for (int i = 0; i < BRB_DEPTH; i++) ring_store[i] = 8'h00;
        ring_wr   = '0;
        ring_rd   = '0;
        ring_mark = '0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i])
            offer_op(dir_rows[i].op, dir_rows[i].data, dir_rows[i].count,
                     dir_rows[i].typed, dir_rows[i].want);

        run_phase(560);
        pause_until_drained();

        send_idle_pct = 82;
        recv_idle_pct = 6;
        run_phase(560);
        pause_until_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // long receiver hold-off: result register stays full and input stalls
        hold_left = 600;
        run_phase(560);
        pause_until_drained();

        repeat (50) @(posedge aclk);

        $display("Ran %0d transactions through all operations and the unused code,",
                 items_sent);
        $display("with %0d refusals for space or data and %0d full-buffer results; %0d checked.",
                 refusals, full_hits, results_seen);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
